// ----- hdl/grm_pkg.sv -----
// ---------------------------------------------------------------------------
// grm_pkg
// Shared types and constants for the grid region merge block.
// ---------------------------------------------------------------------------
package grm_pkg;

  localparam int LABEL_W   = 10;
  localparam int COUNT_W   = 11;
  localparam int COORD_W   = 6;
  localparam int CFG_W     = 7;
  localparam int STATUS_W  = 2;
  localparam int CFG_IDX_W = 1;

  localparam int GRID_SIDE_DEF = 64;

  localparam logic [LABEL_W-1:0] LABEL_MAX      = 10'd1023;
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 11'd2047;
  localparam logic [CFG_W-1:0]   CFG_SIDE_RESET = 7'd63;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_CARVED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_JOINED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_WALL   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [LABEL_W-1:0]  kept;
    logic [LABEL_W-1:0]  dropped;
    logic [COUNT_W-1:0]  regions;
  } res_t;

endpackage

// ----- hdl/grm_ram.sv -----
// ---------------------------------------------------------------------------
// grm_ram
// Label store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module grm_ram import grm_pkg::*; #(
  parameter int AW = 12
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [LABEL_W-1:0] wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [LABEL_W-1:0] rdata
);

  logic [LABEL_W-1:0] mem [(1 << AW)];
  logic [LABEL_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/grm_ctrl.sv -----
// ---------------------------------------------------------------------------
// grm_ctrl
// Sequencer: renumber sweep, neighbor probe, merge decision, relabel sweep.
// ---------------------------------------------------------------------------
module grm_ctrl import grm_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF,
  localparam int CW = $clog2(GRID_SIDE),
  localparam int AW = 2 * CW
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [COORD_W-1:0] in_wall_row,
  input  logic [COORD_W-1:0] in_wall_col,
  input  logic               in_restart,
  input  logic [CFG_W-1:0]   grid_rows,
  input  logic [CFG_W-1:0]   grid_cols,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output logic [LABEL_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [AW-1:0]      ram_raddr,
  input  logic [LABEL_W-1:0] ram_rdata
);

  localparam int SW  = $clog2(GRID_SIDE + 1);
  localparam int XW  = ((SW > 7) ? SW : 7) + 1;
  localparam logic [XW-1:0] SIDE_X = XW'(GRID_SIDE);
  localparam logic [CW-1:0] LAST_IDX = CW'(GRID_SIDE - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_PROBE = 3'd2;
  localparam logic [2:0] S_CHK   = 3'd3;
  localparam logic [2:0] S_SWEEP = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]          state_r, state_nxt;
  logic [COORD_W-1:0]  row_r, row_nxt, col_r, col_nxt;
  logic [SW-1:0]       rows_r, rows_nxt, cols_r, cols_nxt;
  logic [CW-1:0]       ir_r, ir_nxt, jc_r, jc_nxt;
  logic [2:0]          k_r, k_nxt;
  logic [LABEL_W-1:0]  nb_r [4];
  logic [LABEL_W-1:0]  nb_nxt [4];
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [LABEL_W-1:0]  lo_r, lo_nxt, hi_r, hi_nxt;
  logic [LABEL_W-1:0]  next_r, next_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic                s1_vld_r, s1_vld_nxt;
  logic [AW-1:0]       s1_addr_r, s1_addr_nxt;

  logic [XW-1:0] rx, cx, rows_x, cols_x, ix, jx, nr, nc;
  logic [XW-1:0] rows_in, cols_in;
  logic          carvable, init_cell, init_last, sw_row_last, sw_col_last;
  logic          ab_ok, ud_ok, ab_diff, ud_diff;
  logic [LABEL_W-1:0] pa, pb, m_lo, m_hi;

  assign rx     = XW'(row_r);
  assign cx     = XW'(col_r);
  assign rows_x = XW'(rows_r);
  assign cols_x = XW'(cols_r);
  assign ix     = XW'(ir_r);
  assign jx     = XW'(jc_r);

  assign rows_in = (XW'(grid_rows) > SIDE_X) ? SIDE_X : XW'(grid_rows);
  assign cols_in = (XW'(grid_cols) > SIDE_X) ? SIDE_X : XW'(grid_cols);

  assign carvable = (rx >= XW'(1)) && (rx + XW'(2) <= rows_x) &&
                    (cx >= XW'(1)) && (cx + XW'(2) <= cols_x) &&
                    (row_r[0] ^ col_r[0]);
  assign init_cell = (ix >= XW'(1)) && (ix + XW'(2) <= rows_x) &&
                     (jx >= XW'(1)) && (jx + XW'(2) <= cols_x) &&
                     ir_r[0] && jc_r[0];
  assign init_last   = (ir_r == LAST_IDX) && (jc_r == LAST_IDX);
  assign sw_col_last = (jx == cols_x - XW'(2));
  assign sw_row_last = (ix == rows_x - XW'(2));

  // probe order: left, right, up, down
  always_comb begin
    case (k_r)
      3'd0: begin
        nr = rx;
        nc = cx - XW'(1);
      end
      3'd1: begin
        nr = rx;
        nc = cx + XW'(1);
      end
      3'd2: begin
        nr = rx - XW'(1);
        nc = cx;
      end
      default: begin
        nr = rx + XW'(1);
        nc = cx;
      end
    endcase
  end

  assign ab_ok   = (nb_r[0] != '0) && (nb_r[1] != '0);
  assign ud_ok   = (nb_r[2] != '0) && (nb_r[3] != '0);
  assign ab_diff = ab_ok && (nb_r[0] != nb_r[1]);
  assign ud_diff = ud_ok && (nb_r[2] != nb_r[3]);
  assign pa      = ab_diff ? nb_r[0] : nb_r[2];
  assign pb      = ab_diff ? nb_r[1] : nb_r[3];
  assign m_lo    = (pa < pb) ? pa : pb;
  assign m_hi    = (pa < pb) ? pb : pa;

  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    col_nxt     = col_r;
    rows_nxt    = rows_r;
    cols_nxt    = cols_r;
    ir_nxt      = ir_r;
    jc_nxt      = jc_r;
    k_nxt       = k_r;
    nb_nxt      = nb_r;
    status_nxt  = status_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    next_nxt    = next_r;
    cnt_nxt     = cnt_r;
    s1_vld_nxt  = s1_vld_r;
    s1_addr_nxt = s1_addr_r;
    ram_we      = 1'b0;
    ram_waddr   = {ir_r, jc_r};
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = {nr[CW-1:0], nc[CW-1:0]};

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          row_nxt  = in_wall_row;
          col_nxt  = in_wall_col;
          rows_nxt = rows_in[SW-1:0];
          cols_nxt = cols_in[SW-1:0];
          k_nxt    = 3'd0;
          ir_nxt   = '0;
          jc_nxt   = '0;
          if (in_restart) begin
            next_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = S_INIT;
          end else begin
            state_nxt = S_PROBE;
          end
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = {ir_r, jc_r};
        if (init_cell) begin
          ram_wdata = (next_r < LABEL_MAX) ? next_r + LABEL_W'(1) : next_r;
          next_nxt  = ram_wdata;
          if (cnt_r < COUNT_MAX) begin
            cnt_nxt = cnt_r + COUNT_W'(1);
          end
        end
        if (jc_r == LAST_IDX) begin
          jc_nxt = '0;
          ir_nxt = ir_r + CW'(1);
        end else begin
          jc_nxt = jc_r + CW'(1);
        end
        if (init_last) begin
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!carvable) begin
          status_nxt = ST_WALL;
          lo_nxt     = '0;
          hi_nxt     = '0;
          state_nxt  = S_DONE;
        end else begin
          ram_re = (k_r != 3'd4);
          if (k_r != 3'd0) begin
            nb_nxt[k_r[1:0] - 2'd1] = ram_rdata;
          end
          if (k_r == 3'd4) begin
            k_nxt     = 3'd0;
            state_nxt = S_CHK;
          end else begin
            k_nxt = k_r + 3'd1;
          end
        end
      end
      S_CHK: begin
        if (ab_diff || ud_diff) begin
          status_nxt = ST_CARVED;
          lo_nxt     = m_lo;
          hi_nxt     = m_hi;
          ram_we     = 1'b1;
          ram_waddr  = {rx[CW-1:0], cx[CW-1:0]};
          ram_wdata  = m_lo;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - COUNT_W'(1);
          end
          ir_nxt    = CW'(1);
          jc_nxt    = CW'(1);
          state_nxt = S_SWEEP;
        end else begin
          status_nxt = (ab_ok || ud_ok) ? ST_JOINED : ST_WALL;
          lo_nxt     = '0;
          hi_nxt     = '0;
          state_nxt  = S_DONE;
        end
      end
      S_SWEEP, S_DRAIN: begin
        // read one entry per cycle, rewrite the one read the cycle before if it holds hi
        if (s1_vld_r && (ram_rdata == hi_r)) begin
          ram_we    = 1'b1;
          ram_waddr = s1_addr_r;
          ram_wdata = lo_r;
        end
        if (state_r == S_SWEEP) begin
          ram_re      = 1'b1;
          ram_raddr   = {ir_r, jc_r};
          s1_vld_nxt  = 1'b1;
          s1_addr_nxt = {ir_r, jc_r};
          if (sw_col_last) begin
            jc_nxt = CW'(1);
            ir_nxt = ir_r + CW'(1);
            if (sw_row_last) begin
              state_nxt = S_DRAIN;
            end
          end else begin
            jc_nxt = jc_r + CW'(1);
          end
        end else begin
          s1_vld_nxt = 1'b0;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      s1_vld_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      s1_vld_r <= s1_vld_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r     <= row_nxt;
    col_r     <= col_nxt;
    rows_r    <= rows_nxt;
    cols_r    <= cols_nxt;
    ir_r      <= ir_nxt;
    jc_r      <= jc_nxt;
    k_r       <= k_nxt;
    nb_r      <= nb_nxt;
    status_r  <= status_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    next_r    <= next_nxt;
    s1_addr_r <= s1_addr_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign res_valid   = (state_r == S_DONE);
  assign res.status  = status_r;
  assign res.kept    = lo_r;
  assign res.dropped = hi_r;
  assign res.regions = cnt_r;

endmodule

// ----- hdl/grid_region_merge_by_relabel.sv -----
// ---------------------------------------------------------------------------
// grid_region_merge_by_relabel
// Region label grid with wall carving and merge-by-relabel.
// ---------------------------------------------------------------------------
// One item is worked at a time through a simple dual-port label RAM (one read
// and one write per cycle). An item is taken in the idle state and its result
// is handed to the output register from the done state. A restart first
// renumbers the whole store. A try on a carvable wall position then probes the
// four neighbors; a carved wall adds a relabel sweep over the interior of the
// current size. A finished result sits in an output register, so the next
// item may be accepted while it waits to be taken.
// ---------------------------------------------------------------------------
module grid_region_merge_by_relabel import grm_pkg::*; #(
  parameter int GRID_SIDE = GRID_SIDE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [COORD_W-1:0]   in_wall_row,
  input  logic [COORD_W-1:0]   in_wall_col,
  input  logic                 in_restart,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [LABEL_W-1:0]   out_kept_label,
  output logic [LABEL_W-1:0]   out_dropped_label,
  output logic [COUNT_W-1:0]   out_regions_left,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int AW = 2 * $clog2(GRID_SIDE);

  logic [CFG_W-1:0]   grid_rows_r, grid_cols_r;
  logic               res_valid, res_ready;
  res_t               res;
  res_t               out_r;
  logic               out_valid_r;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [LABEL_W-1:0] ram_wdata, ram_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= CFG_SIDE_RESET;
      grid_cols_r <= CFG_SIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROWS: grid_rows_r <= cfg_data;
        CFG_COLS: grid_cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  grm_ctrl #(
    .GRID_SIDE (GRID_SIDE)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_wall_row (in_wall_row),
    .in_wall_col (in_wall_col),
    .in_restart  (in_restart),
    .grid_rows   (grid_rows_r),
    .grid_cols   (grid_cols_r),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata)
  );

  grm_ram #(
    .AW (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_kept_label    = out_r.kept;
  assign out_dropped_label = out_r.dropped;
  assign out_regions_left  = out_r.regions;

endmodule

// ----- hdl/grm_checker.sv -----
// ---------------------------------------------------------------------------
// grm_checker
// Port-level checks for the grid region merge block, bound to the top level.
// ---------------------------------------------------------------------------
module grm_checker import grm_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [STATUS_W-1:0]  out_status,
  input logic [LABEL_W-1:0]   out_kept_label,
  input logic [LABEL_W-1:0]   out_dropped_label,
  input logic [COUNT_W-1:0]   out_regions_left
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable(out_status) && $stable(out_kept_label) &&
      $stable(out_dropped_label) && $stable(out_regions_left))
    else $error("result changed while stalled");

  // labels only on a carve
  a_no_carve_labels: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_CARVED |->
      out_kept_label == '0 && out_dropped_label == '0)
    else $error("labels reported without a carve");

  // a carve merges two distinct nonzero labels, smaller one kept
  a_carve_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CARVED |->
      out_kept_label != '0 && out_kept_label < out_dropped_label)
    else $error("bad label pair on carve");

  // one item at a time: no back-to-back transfers on the input
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

endmodule

bind grid_region_merge_by_relabel grm_checker u_grm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_status        (out_status),
  .out_kept_label    (out_kept_label),
  .out_dropped_label (out_dropped_label),
  .out_regions_left  (out_regions_left)
);

// ----- tb/sv/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Checks the grid region merge block against a built-in label grid predictor:
// directed tries on border, cell, wall and outside positions at several grid
// sizes, then random phases of wall tries with random sizes, restarts and
// random stalls on both channels.
// ---------------------------------------------------------------------------
module testbench import grm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 50000;
  localparam int TAIL_CYCLES = 8200;

  // label grid and region counter, updated in transfer order
  class region_merge_checker;
    logic [LABEL_W-1:0] labels [GRID_SIDE_DEF*GRID_SIDE_DEF];
    int unsigned        regions;
    int unsigned        rows_used;
    int unsigned        cols_used;
    res_t               expected_merges[$];
    int unsigned        fail_count;

    function new();
      foreach (labels[k]) labels[k] = '0;
      regions    = 0;
      rows_used  = CFG_SIDE_RESET;
      cols_used  = CFG_SIDE_RESET;
      fail_count = 0;
    endfunction

    // sizes above the grid side saturate
    function void set_size(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      int unsigned v;
      v = (val > GRID_SIDE_DEF) ? GRID_SIDE_DEF : val;
      if (idx == CFG_ROWS) rows_used = v;
      else cols_used = v;
    endfunction

    function void predict_wall_try(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                   logic renumber);
      int unsigned r, c, i, j, next, lo, hi, a, b, u, d;
      res_t want;
      r = row;
      c = col;
      lo = 0;
      hi = 0;
      want.status = ST_WALL;
      if (renumber) begin
        next = 0;
        regions = 0;
        for (i = 0; i < GRID_SIDE_DEF; i++) begin
          for (j = 0; j < GRID_SIDE_DEF; j++) begin
            if (i >= 1 && i + 2 <= rows_used && j >= 1 && j + 2 <= cols_used &&
                i[0] && j[0]) begin
              if (next < LABEL_MAX) next++;
              if (regions < COUNT_MAX) regions++;
              labels[i*GRID_SIDE_DEF + j] = LABEL_W'(next);
            end else begin
              labels[i*GRID_SIDE_DEF + j] = '0;
            end
          end
        end
      end
      if (r >= 1 && r + 2 <= rows_used && c >= 1 && c + 2 <= cols_used &&
          ((r + c) % 2 == 1)) begin
        a = labels[r*GRID_SIDE_DEF + c - 1];
        b = labels[r*GRID_SIDE_DEF + c + 1];
        u = labels[(r-1)*GRID_SIDE_DEF + c];
        d = labels[(r+1)*GRID_SIDE_DEF + c];
        // left/right pair wins when both qualify
        if (a != 0 && b != 0 && a != b) begin
          lo = (a < b) ? a : b;
          hi = (a < b) ? b : a;
          want.status = ST_CARVED;
        end else if (u != 0 && d != 0 && u != d) begin
          lo = (u < d) ? u : d;
          hi = (u < d) ? d : u;
          want.status = ST_CARVED;
        end else if ((a != 0 && b != 0) || (u != 0 && d != 0)) begin
          want.status = ST_JOINED;
        end
        if (want.status == ST_CARVED) begin
          labels[r*GRID_SIDE_DEF + c] = LABEL_W'(lo);
          for (i = 1; i + 1 < rows_used; i++)
            for (j = 1; j + 1 < cols_used; j++)
              if (labels[i*GRID_SIDE_DEF + j] == hi)
                labels[i*GRID_SIDE_DEF + j] = LABEL_W'(lo);
          if (regions > 0) regions--;
        end
      end
      want.kept    = LABEL_W'(lo);
      want.dropped = LABEL_W'(hi);
      want.regions = COUNT_W'(regions);
      expected_merges = {expected_merges, want};
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_merges.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected result: status %0d kept %0d dropped %0d regions %0d",
                   got.status, got.kept, got.dropped, got.regions);
        return;
      end
      want = expected_merges.pop_front();
      if (got.status !== want.status || got.kept !== want.kept ||
          got.dropped !== want.dropped || got.regions !== want.regions) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"mismatch: expected status %0d kept %0d dropped %0d regions %0d,",
                    " got status %0d kept %0d dropped %0d regions %0d"},
                   want.status, want.kept, want.dropped, want.regions,
                   got.status, got.kept, got.dropped, got.regions);
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [COORD_W-1:0]   in_wall_row = '0;
  logic [COORD_W-1:0]   in_wall_col = '0;
  logic                 in_restart = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  out_status;
  logic [LABEL_W-1:0]   out_kept_label;
  logic [LABEL_W-1:0]   out_dropped_label;
  logic [COUNT_W-1:0]   out_regions_left;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ROWS;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic                 steady = 1'b0;
  int unsigned          stall_cycles = 0;
  region_merge_checker  sb;

  grid_region_merge_by_relabel dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_wall_row       (in_wall_row),
    .in_wall_col       (in_wall_col),
    .in_restart        (in_restart),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_kept_label    (out_kept_label),
    .out_dropped_label (out_dropped_label),
    .out_regions_left  (out_regions_left),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 16);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{status: out_status, kept: out_kept_label,
                        dropped: out_dropped_label, regions: out_regions_left});
  end

  // a restart plus a full-size sweep is the longest silent stretch
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("grid_region_merge_by_relabel verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_try(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                          input logic renumber);
    while (!steady && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_wall_row <= row;
    in_wall_col <= col;
    in_restart  <= renumber;
    do @(posedge clk); while (!in_ready);
    sb.predict_wall_try(row, col, renumber);
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (sb.expected_merges.size() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_size(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data  <= rows;
    @(posedge clk);
    sb.set_size(CFG_ROWS, rows);
    cfg_index <= CFG_COLS;
    cfg_data  <= cols;
    @(posedge clk);
    sb.set_size(CFG_COLS, cols);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CFG_W-1:0] pick_side();
    int unsigned x;
    x = $urandom_range(0, 99);
    if (x < 8) return CFG_W'($urandom_range(0, 2));
    if (x < 16) return CFG_W'($urandom_range(40, 127));
    return CFG_W'($urandom_range(3, 16));
  endfunction

  // mostly interior walls; the rest anywhere in the coordinate space
  task automatic random_try(input logic renumber);
    int unsigned r, c;
    if ($urandom_range(0, 99) < 80 && sb.rows_used >= 3 && sb.cols_used >= 3) begin
      r = $urandom_range(1, sb.rows_used - 2);
      c = $urandom_range(1, sb.cols_used - 2);
      if ((r + c) % 2 == 0) begin
        if (c + 1 <= sb.cols_used - 2) c++;
        else if (c > 1) c--;
        else if (r + 1 <= sb.rows_used - 2) r++;
        else if (r > 1) r--;
      end
    end else begin
      r = $urandom_range(0, 63);
      c = $urandom_range(0, 63);
    end
    send_try(COORD_W'(r), COORD_W'(c), renumber);
  endtask

  initial begin
    int phase, n;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // cells at rows 1,3,5 and cols 1,3,5,7
    set_size(8, 9);
    send_try(0, 0, 1'b1);     // restart on the border
    send_try(1, 2, 1'b0);     // horizontal carve
    send_try(2, 1, 1'b0);     // vertical carve
    send_try(1, 2, 1'b0);     // already joined
    send_try(2, 3, 1'b0);
    send_try(3, 2, 1'b0);
    send_try(1, 1, 1'b0);     // a cell, not a wall
    send_try(2, 2, 1'b0);
    send_try(6, 1, 1'b0);     // each neighbor pair holds a zero
    send_try(7, 2, 1'b0);     // outside the rows in use
    send_try(1, 8, 1'b0);
    send_try(63, 63, 1'b0);
    send_try(0, 63, 1'b0);
    send_try(63, 0, 1'b0);
    send_try(5, 6, 1'b1);     // restart and carve in one transfer
    wait_results_done();

    set_size(127, 127);       // saturates to the full grid
    send_try(62, 1, 1'b1);
    send_try(61, 60, 1'b0);
    send_try(1, 2, 1'b0);
    wait_results_done();

    set_size(64, 3);
    send_try(2, 1, 1'b1);
    send_try(62, 1, 1'b0);
    send_try(4, 1, 1'b0);
    wait_results_done();

    set_size(3, 64);          // no restart: old labels stay
    send_try(1, 2, 1'b0);
    send_try(1, 62, 1'b1);
    wait_results_done();

    set_size(0, 2);           // no interior at all
    send_try(1, 2, 1'b0);
    send_try(0, 0, 1'b1);
    send_try(1, 1, 1'b0);
    wait_results_done();

    for (phase = 0; phase < 10; phase++) begin
      set_size(pick_side(), pick_side());
      steady <= (phase == 3);
      for (n = 0; n < 12; n++) begin
        if (phase == 5 && n == 6) wait_results_done();
        random_try((n == 0 && phase % 3 != 2) || $urandom_range(0, 99) < 5);
      end
      wait_results_done();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.fail_count == 0 && sb.expected_merges.size() == 0)
      $display("grid_region_merge_by_relabel verification clean");
    else
      $display("grid_region_merge_by_relabel verification failed");
    $finish;
  end

endmodule
